/* design/bdq_pkg.sv */
`timescale 1ns / 1ps
package bdq_pkg;

  localparam int DATA_W = 32;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 2;

  // operation codes on func
  localparam logic [FUNC_W-1:0] FN_LIST      = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INS_REAR  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REM_FRONT = 3'd3;
  localparam logic [FUNC_W-1:0] FN_REM_REAR  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_QUERY     = 3'd5;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic latch;    // capture the incoming item
    logic exec;     // perform the operation on the ring
    logic rd_next;  // step the listing index and read the next entry
    logic emit;     // load the output register
  } bdq_cmd_t;

  typedef struct packed {
    logic in_legal;    // func on the port is a defined operation
    logic needs_read;  // latched operation reads the store
    logic more;        // listing has further entries after the current one
    logic out_free;    // output register can take a result this cycle
  } bdq_stat_t;

endpackage

/* design/bdq_ctrl.sv */
`timescale 1ns / 1ps
module bdq_ctrl import bdq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  bdq_stat_t stat,
  output bdq_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WAIT = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          // unused codes are dropped here
          if (stat.in_legal) begin
            state_next = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_next = stat.needs_read ? S_WAIT : S_EMIT;
      end
      S_WAIT: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.more) begin
            cmd.rd_next = 1'b1;
            state_next  = S_WAIT;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* design/bdq_dpath.sv */
`timescale 1ns / 1ps
module bdq_dpath import bdq_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [FUNC_W-1:0]        func,
  input  logic signed [DATA_W-1:0] item_value,
  input  bdq_cmd_t                 cmd,
  output bdq_stat_t                stat,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [STAT_W-1:0]        status,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     is_empty,
  output logic                     last_result
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [FUNC_W-1:0]        op;
  logic signed [DATA_W-1:0] val;
  logic [AW-1:0]            front;
  logic [CW-1:0]            count;
  logic [AW-1:0]            idx;
  logic [STAT_W-1:0]        res_status;
  logic                     use_data;

  logic [DATA_W-1:0]        mem [CAPACITY];
  logic [DATA_W-1:0]        rd_data;

  logic          full, empty;
  logic [AW-1:0] front_dec;
  logic [CW-1:0] idx_inc;
  logic          is_ins, is_rem;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;

  // store index at an offset from a base; sum stays below twice the capacity
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(CAPACITY)) begin
      sum = sum - (CW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);
  assign front_dec = (front == '0) ? AW'(CAPACITY - 1) : front - AW'(1);
  assign idx_inc   = CW'(idx) + CW'(1);
  assign is_ins    = (op == FN_INS_FRONT) || (op == FN_INS_REAR);
  assign is_rem    = (op == FN_REM_FRONT) || (op == FN_REM_REAR);

  assign stat.in_legal   = (func <= FN_QUERY);
  assign stat.needs_read = !empty && (is_rem || (op == FN_LIST));
  assign stat.more       = (op == FN_LIST) && use_data && (idx_inc < count);
  assign stat.out_free   = !out_valid || out_ready;

  assign wr_en   = cmd.exec && is_ins && !full;
  assign wr_addr = (op == FN_INS_FRONT) ? front_dec : ring_pos(front, count);
  assign rd_en   = (cmd.exec && stat.needs_read) || cmd.rd_next;

  always_comb begin
    if (cmd.rd_next) begin
      rd_addr = ring_pos(front, idx_inc);
    end else if (op == FN_REM_REAR) begin
      rd_addr = ring_pos(front, count - CW'(1));
    end else begin
      rd_addr = front;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= val;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        case (op)
          FN_INS_FRONT: begin
            if (!full) begin
              front <= front_dec;
              count <= count + CW'(1);
            end
          end
          FN_INS_REAR: begin
            if (!full) begin
              count <= count + CW'(1);
            end
          end
          FN_REM_FRONT: begin
            if (!empty) begin
              front <= ring_pos(front, CW'(1));
              count <= count - CW'(1);
            end
          end
          FN_REM_REAR: begin
            if (!empty) begin
              count <= count - CW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op  <= func;
      val <= item_value;
    end
    if (cmd.exec) begin
      idx      <= '0;
      use_data <= stat.needs_read;
      if (is_ins) begin
        res_status <= full ? ST_FULL : ST_OK;
      end else begin
        res_status <= empty ? ST_EMPTY : ST_OK;
      end
    end else if (cmd.rd_next) begin
      idx <= idx_inc[AW-1:0];
    end
    if (cmd.emit) begin
      status      <= res_status;
      out_value   <= use_data ? rd_data : '0;
      is_empty    <= empty;
      last_result <= !stat.more;
    end
  end

endmodule

/* design/bounded_double_ended_queue_top.sv */
`timescale 1ns / 1ps
// Bounded double-ended queue of signed 32-bit values in a ring memory.
// Input channel (in_valid/in_ready): func selects list, insert front,
// insert rear, remove front, remove rear or query empty; item_value is
// the value to insert. Codes 6 and 7 are accepted and dropped.
// Output channel (out_valid/out_ready): status, out_value, is_empty and
// last_result per result; last_result marks the final result of an item.
// One item is worked at a time; in_ready is high only while the block is
// idle. An accepted item passes the execute state and then the emit
// state, where the output register is loaded; a remove or listing on a
// nonempty queue takes a wait state between them for the registered read.
// A listing emits its stored values front to rear, one read of the single
// memory read port per value, each read followed by the wait state.
// A stalled receiver holds the output register; the block waits with it.
// Reset clears the front position, the count and the output valid; the
// queue is empty afterwards and memory contents are not cleared.
module bounded_double_ended_queue_top import bdq_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [FUNC_W-1:0]        func,
  input  logic signed [DATA_W-1:0] item_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        status,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     is_empty,
  output logic                     last_result
);

  bdq_cmd_t  cmd;
  bdq_stat_t stat;

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bdq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .func        (func),
    .item_value  (item_value),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .status      (status),
    .out_value   (out_value),
    .is_empty    (is_empty),
    .last_result (last_result)
  );

endmodule

/* design/bdq_checker.sv */
`timescale 1ns / 1ps
module bdq_checker import bdq_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [STAT_W-1:0]        status,
  input logic signed [DATA_W-1:0] out_value,
  input logic                     is_empty,
  input logic                     last_result
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_value)
      && $stable(is_empty) && $stable(last_result))
    else $error("stalled result changed");

  // empty status means the queue is empty and no value is carried
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> is_empty && out_value == '0)
    else $error("empty status inconsistent");

  // full status means the queue is not empty, the item ends and no value is carried
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> !is_empty && last_result && out_value == '0)
    else $error("full status inconsistent");

  // anything but a plain ok ends the item
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || ((status == ST_EMPTY || status == ST_FULL)
      && last_result))
    else $error("bad status code");

endmodule

bind bounded_double_ended_queue_top bdq_checker u_bdq_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .out_value   (out_value),
  .is_empty    (is_empty),
  .last_result (last_result)
);

/* verif/tb.sv */
`timescale 1ns / 1ps
module tb import bdq_pkg::*;;

  localparam int CAP         = 64;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  // func codes the block accepts and drops
  localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  typedef struct {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] value;
    logic                     empty;
    logic                     last;
  } deque_result_t;

  class deque_scoreboard;
    logic signed [DATA_W-1:0] ring [CAP];
    int head;
    int fill;
    int errors;
    deque_result_t due_q[$];

    function new();
      head   = 0;
      fill   = 0;
      errors = 0;
    endfunction

    function void push_result(logic [STAT_W-1:0] st, logic signed [DATA_W-1:0] v,
                              logic last);
      deque_result_t r;
      r.status = st;
      r.value  = v;
      r.empty  = (fill == 0);
      r.last   = last;
      due_q.push_back(r);
    endfunction

    // apply one accepted item to the shadow deque and queue its results
    function void note_item(logic [FUNC_W-1:0] f, logic signed [DATA_W-1:0] v);
      int pos;
      case (f)
        FN_LIST: begin
          if (fill == 0) begin
            push_result(ST_EMPTY, '0, 1'b1);
          end else begin
            for (int i = 0; i < fill; i++)
              push_result(ST_OK, ring[(head + i) % CAP], i == fill - 1);
          end
        end
        FN_INS_FRONT, FN_INS_REAR: begin
          if (fill == CAP) begin
            push_result(ST_FULL, '0, 1'b1);
          end else begin
            if (f == FN_INS_FRONT) begin
              head = (head + CAP - 1) % CAP;
              ring[head] = v;
            end else begin
              ring[(head + fill) % CAP] = v;
            end
            fill++;
            push_result(ST_OK, '0, 1'b1);
          end
        end
        FN_REM_FRONT, FN_REM_REAR: begin
          if (fill == 0) begin
            push_result(ST_EMPTY, '0, 1'b1);
          end else begin
            if (f == FN_REM_FRONT) begin
              pos  = head;
              head = (head + 1) % CAP;
            end else begin
              pos = (head + fill - 1) % CAP;
            end
            fill--;
            push_result(ST_OK, ring[pos], 1'b1);
          end
        end
        FN_QUERY: push_result((fill == 0) ? ST_EMPTY : ST_OK, '0, 1'b1);
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [STAT_W-1:0] st, logic signed [DATA_W-1:0] v,
                      logic e, logic l);
      deque_result_t want;
      if (due_q.size() == 0) begin
        report_mismatch($sformatf("result with none due: status %0d value %0d", st, v));
      end else begin
        want = due_q.pop_front();
        if (st !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", st, want.status));
        if (v !== want.value)
          report_mismatch($sformatf("out_value %0d, want %0d", v, want.value));
        if (e !== want.empty)
          report_mismatch($sformatf("is_empty %0b, want %0b", e, want.empty));
        if (l !== want.last)
          report_mismatch($sformatf("last_result %0b, want %0b", l, want.last));
      end
    endtask

    function int outstanding();
      return due_q.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [FUNC_W-1:0]        func = '0;
  logic signed [DATA_W-1:0] item_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] out_value;
  logic                     is_empty;
  logic                     last_result;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_req      = 0;

  deque_scoreboard sb;

  bounded_double_ended_queue_top #(.CAPACITY(CAP)) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .item_value  (item_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .out_value   (out_value),
    .is_empty    (is_empty),
    .last_result (last_result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_item(func, item_value);
      if (out_valid && out_ready)
        sb.check_result(status, out_value, is_empty, last_result);
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task send_item(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    item_value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold the sender until every due result is back, then let dropped items settle
  task wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function logic signed [DATA_W-1:0] random_value();
    case ($urandom_range(7))
      0: return {1'b1, {(DATA_W-1){1'b0}}};
      1: return {1'b0, {(DATA_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function logic [FUNC_W-1:0] pick_func(int insert_pct);
    int r;
    r = $urandom_range(99);
    if (r < 4)
      return $urandom_range(1) ? FN_SPARE_6 : FN_SPARE_7;
    if (r < 10)
      return FN_LIST;
    if (r < 16)
      return FN_QUERY;
    if ($urandom_range(99) < insert_pct)
      return $urandom_range(1) ? FN_INS_FRONT : FN_INS_REAR;
    return $urandom_range(1) ? FN_REM_FRONT : FN_REM_REAR;
  endfunction

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty queue corner cases, extremes of item_value, spare codes
    send_item(FN_QUERY, '0);
    send_item(FN_LIST, '0);
    send_item(FN_REM_FRONT, '0);
    send_item(FN_REM_REAR, '0);
    send_item(FN_SPARE_6, '1);
    send_item(FN_SPARE_7, '0);
    send_item(FN_INS_FRONT, 32'sh7fffffff);
    send_item(FN_INS_REAR, 32'sh80000000);
    send_item(FN_INS_FRONT, '0);
    send_item(FN_INS_REAR, '1);
    send_item(FN_QUERY, '0);
    send_item(FN_LIST, '0);
    send_item(FN_REM_REAR, '0);
    send_item(FN_REM_FRONT, '0);
    send_item(FN_LIST, '0);
    send_item(FN_REM_FRONT, '0);
    send_item(FN_REM_REAR, '0);
    send_item(FN_REM_REAR, '0);
    send_item(FN_QUERY, '0);
    send_item(FN_LIST, '0);
    wait_drained();

    // receiver holds off while inserts pile up; overfill, then list a full queue
    hold_req = HOLD_CYCLES;
    for (int i = 0; i < CAP + 2; i++)
      send_item((i % 2) ? FN_INS_REAR : FN_INS_FRONT, random_value());
    send_item(FN_QUERY, '0);
    send_item(FN_LIST, '0);
    send_item(FN_INS_FRONT, random_value());
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 74; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 74; end
        default: begin send_idle_pct = 25; stall_pct = 25; end
      endcase
      // alternate drain-heavy and fill-heavy stretches to sweep the fill level
      for (int seg = 0; seg < 5; seg++) begin
        for (int k = 0; k < 25; k++)
          send_item(pick_func((seg % 2) ? 80 : 20), random_value());
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
design/bdq_pkg.sv
design/bdq_ctrl.sv
design/bdq_dpath.sv
design/bounded_double_ended_queue_top.sv
design/bdq_checker.sv
verif/tb.sv
